// ----- rtl/sandpile_drop_and_relax_unit_assert.svh -----
// Assertion macros shared by the sandpile checker.
`ifndef SANDPILE_DROP_AND_RELAX_UNIT_ASSERT_SVH
`define SANDPILE_DROP_AND_RELAX_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SDR_ASSERT_NOW(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SDR_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/sdr_pkg.sv -----
// Shared types and constants of the sandpile drop-and-relax unit.
package sdr_pkg;

    localparam int DROP_W    = 5;
    localparam int S_TDATA_W = 16;
    localparam int COUNT_W   = 24;
    localparam int M_TDATA_W = 32;
    localparam int TOPPLE_AT = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic               sat;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

// ----- rtl/sdr_ram.sv -----
// Simple dual-port synchronous RAM with a registered read.
module sdr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sdr_relax_ctrl.sv -----
// Relaxation sequencer: drop, stack of unstable cells, read-modify-write topplings.
module sdr_relax_ctrl #(
    parameter int GRID_SIDE = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [sdr_pkg::DROP_W-1:0]            in_row,
    input  logic [sdr_pkg::DROP_W-1:0]            in_col,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output sdr_pkg::result_t                      res,
    output logic                                  g_we,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] g_waddr,
    output logic [$clog2(3*GRID_SIDE*GRID_SIDE+2)-1:0] g_wdata,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] g_raddr,
    input  logic [$clog2(3*GRID_SIDE*GRID_SIDE+2)-1:0] g_rdata,
    output logic                                  k_we,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] k_waddr,
    output logic [2*$clog2(GRID_SIDE)-1:0]        k_wdata,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] k_raddr,
    input  logic [2*$clog2(GRID_SIDE)-1:0]        k_rdata
);

    localparam int N      = GRID_SIDE * GRID_SIDE;
    localparam int RW     = $clog2(GRID_SIDE);
    localparam int AW     = $clog2(N);
    localparam int SPW    = $clog2(N + 1);
    // Grains are never created, so no cell ever holds more than 3*N+1.
    localparam int CELL_W = $clog2(3 * N + 2);
    localparam int CW     = sdr_pkg::COUNT_W;

    localparam logic [RW-1:0]     SIDE_LAST = RW'(GRID_SIDE - 1);
    localparam logic [CELL_W-1:0] THRESH    = CELL_W'(sdr_pkg::TOPPLE_AT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NB_WR,
        ST_POP,
        ST_CEN_RD,
        ST_CEN_WR,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [RW-1:0]     cur_col_reg, cur_col_next;
    logic [RW-1:0]     tgt_row_reg, tgt_row_next;
    logic [RW-1:0]     tgt_col_reg, tgt_col_next;
    logic [3:0]        mask_reg, mask_next;
    logic [CELL_W-1:0] add_reg, add_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    logic [SPW-1:0]    sp_dec;
    logic [3:0]        full_mask;
    logic [3:0]        cur_mask;
    logic [3:0]        low_bit;
    logic [RW-1:0]     nb_row;
    logic [RW-1:0]     nb_col;
    logic [CELL_W-1:0] sum;
    logic              push;
    logic [CELL_W-1:0] k_amt;
    logic [CW:0]       cnt_sum;
    logic              in_range;
    logic [RW-1:0]     drop_row;
    logic [RW-1:0]     drop_col;
    logic [RW-1:0]     pop_row;
    logic [RW-1:0]     pop_col;

    function automatic logic [AW-1:0] cell_idx(input logic [RW-1:0] r,
                                               input logic [RW-1:0] c);
        cell_idx = AW'(int'(r) * GRID_SIDE + int'(c));
    endfunction

    assign sp_dec   = sp_reg - 1'b1;
    assign in_range = (int'(in_row) < GRID_SIDE) && (int'(in_col) < GRID_SIDE);
    assign drop_row = RW'(in_row);
    assign drop_col = RW'(in_col);
    assign pop_row  = k_rdata[2*RW-1:RW];
    assign pop_col  = k_rdata[RW-1:0];
    assign sum      = g_rdata + add_reg;
    assign push     = (g_rdata < THRESH) && (sum >= THRESH);
    assign k_amt    = g_rdata >> 2;
    assign cnt_sum  = {1'b0, cnt_reg} + (CW+1)'(k_amt);

    // neighbor order: up, down, left, right
    assign full_mask = {cur_col_reg != SIDE_LAST, cur_col_reg != '0,
                        cur_row_reg != SIDE_LAST, cur_row_reg != '0};
    assign cur_mask  = (state_reg == ST_CEN_WR) ? full_mask : mask_reg;
    assign low_bit   = cur_mask & (~cur_mask + 4'd1);

    always_comb
    begin
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        if (cur_mask[0])
        begin
            nb_row = cur_row_reg - 1'b1;
        end
        else if (cur_mask[1])
        begin
            nb_row = cur_row_reg + 1'b1;
        end
        else if (cur_mask[2])
        begin
            nb_col = cur_col_reg - 1'b1;
        end
        else
        begin
            nb_col = cur_col_reg + 1'b1;
        end
    end

    assign res.count = cnt_reg;
    assign res.sat   = (cnt_reg == sdr_pkg::COUNT_MAX);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        sp_next      = sp_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        tgt_row_next = tgt_row_reg;
        tgt_col_next = tgt_col_reg;
        mask_next    = mask_reg;
        add_next     = add_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        g_we         = 1'b0;
        g_waddr      = cell_idx(tgt_row_reg, tgt_col_reg);
        g_wdata      = sum;
        g_raddr      = cell_idx(tgt_row_reg, tgt_col_reg);
        k_we         = 1'b0;
        k_waddr      = sp_reg[AW-1:0];
        k_wdata      = {tgt_row_reg, tgt_col_reg};
        k_raddr      = sp_dec[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                g_we     = 1'b1;
                g_waddr  = clr_reg;
                g_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cnt_next = '0;
                    if (in_range)
                    begin
                        tgt_row_next = drop_row;
                        tgt_col_next = drop_col;
                        g_raddr      = cell_idx(drop_row, drop_col);
                        add_next     = CELL_W'(1);
                        mask_next    = '0;
                        state_next   = ST_NB_WR;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_NB_WR:
            begin
                // add grains to the target; it joins the stack when it crosses the threshold
                g_we = 1'b1;
                if (push)
                begin
                    k_we    = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                if (mask_reg != '0)
                begin
                    tgt_row_next = nb_row;
                    tgt_col_next = nb_col;
                    g_raddr      = cell_idx(nb_row, nb_col);
                    mask_next    = mask_reg & ~low_bit;
                end
                else if (push || (sp_reg != '0))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                sp_next    = sp_dec;
                state_next = ST_CEN_RD;
            end
            ST_CEN_RD:
            begin
                cur_row_next = pop_row;
                cur_col_next = pop_col;
                g_raddr      = cell_idx(pop_row, pop_col);
                state_next   = ST_CEN_WR;
            end
            ST_CEN_WR:
            begin
                // topple fully: keep the remainder, pass the quotient to each neighbor
                g_we         = 1'b1;
                g_waddr      = cell_idx(cur_row_reg, cur_col_reg);
                g_wdata      = g_rdata & CELL_W'(sdr_pkg::TOPPLE_AT - 1);
                cnt_next     = cnt_sum[CW] ? sdr_pkg::COUNT_MAX : cnt_sum[CW-1:0];
                add_next     = k_amt;
                tgt_row_next = nb_row;
                tgt_col_next = nb_col;
                g_raddr      = cell_idx(nb_row, nb_col);
                mask_next    = full_mask & ~low_bit;
                state_next   = ST_NB_WR;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            mask_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            mask_reg  <= mask_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        tgt_row_reg <= tgt_row_next;
        tgt_col_reg <= tgt_col_next;
        add_reg     <= add_next;
    end

endmodule

// ----- rtl/sandpile_drop_and_relax_unit.sv -----
// Top level of the sandpile drop-and-relax unit.
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one drop per beat: the
//   grain lands at (row, col). Master channel (m_tvalid/m_tready/m_tdata)
//   returns one beat per drop: the toppling count of that avalanche and a
//   saturation flag.
//   Sequence: a drop that topples nothing reads and writes its cell, then its
//   result moves to the output register and the next drop can be accepted.
//   Each pop of an unstable cell (it topples fully, however many times) adds
//   a pop from the stack memory, a read-modify-write of the center, then one
//   of each neighbor inside the grid, all through the single write port of
//   the grid memory. One drop is in flight at a time.
//   Drops outside the grid add nothing and return a zero count.
//   Reset: the grid memory is cleared one cell a cycle, all GRID_SIDE*GRID_SIDE
//   cells (1024 by default); s_tready stays low until that pass ends.
//   Stall: the output register holds a finished result while m_tready is low;
//   the next drop is still accepted and relaxed, and its result waits in the
//   sequencer until the register frees.
module sandpile_drop_and_relax_unit #(
    parameter int GRID_SIDE = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sdr_pkg::S_TDATA_W-1:0]   s_tdata,  // drop_row[4:0], drop_col[9:5]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sdr_pkg::M_TDATA_W-1:0]   m_tdata   // topple_count[23:0], count_saturated[24]
);

    localparam int N      = GRID_SIDE * GRID_SIDE;
    localparam int RW     = $clog2(GRID_SIDE);
    localparam int AW     = $clog2(N);
    localparam int CELL_W = $clog2(3 * N + 2);
    localparam int DW     = sdr_pkg::DROP_W;
    localparam int CW     = sdr_pkg::COUNT_W;

    logic              res_valid;
    logic              res_ready;
    sdr_pkg::result_t  res;

    logic              g_we;
    logic [AW-1:0]     g_waddr;
    logic [CELL_W-1:0] g_wdata;
    logic [AW-1:0]     g_raddr;
    logic [CELL_W-1:0] g_rdata;
    logic              k_we;
    logic [AW-1:0]     k_waddr;
    logic [2*RW-1:0]   k_wdata;
    logic [AW-1:0]     k_raddr;
    logic [2*RW-1:0]   k_rdata;

    logic              m_tvalid_reg, m_tvalid_next;
    sdr_pkg::result_t  m_res_reg, m_res_next;

    sdr_relax_ctrl #(
        .GRID_SIDE (GRID_SIDE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_row    (s_tdata[DW-1:0]),
        .in_col    (s_tdata[2*DW-1:DW]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .g_we      (g_we),
        .g_waddr   (g_waddr),
        .g_wdata   (g_wdata),
        .g_raddr   (g_raddr),
        .g_rdata   (g_rdata),
        .k_we      (k_we),
        .k_waddr   (k_waddr),
        .k_wdata   (k_wdata),
        .k_raddr   (k_raddr),
        .k_rdata   (k_rdata)
    );

    // grain counts, one entry per cell
    sdr_ram #(
        .DEPTH (N),
        .WIDTH (CELL_W)
    ) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // stack of unstable cells; a cell is on it at most once
    sdr_ram #(
        .DEPTH (N),
        .WIDTH (2 * RW)
    ) u_stack (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(sdr_pkg::M_TDATA_W - CW - 1){1'b0}}, m_res_reg.sat, m_res_reg.count};

endmodule

// ----- rtl/sdr_checker.sv -----
// Port-level checker for the sandpile drop-and-relax unit, bound to the top level.
`include "sandpile_drop_and_relax_unit_assert.svh"

module sdr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sdr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CW = sdr_pkg::COUNT_W;

    logic [CW-1:0]                      out_count;
    logic                               out_sat;
    logic [sdr_pkg::M_TDATA_W-CW-2:0]   out_pad;

    assign out_count = m_tdata[CW-1:0];
    assign out_sat   = m_tdata[CW];
    assign out_pad   = m_tdata[sdr_pkg::M_TDATA_W-1:CW+1];

    // one drop at a time: the input closes right after a beat
    `SDR_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "drop accepted while busy")

    // flag and count agree
    `SDR_ASSERT_NOW(a_sat_flag, m_tvalid, out_sat == (out_count == sdr_pkg::COUNT_MAX), "sat flag")

    `SDR_ASSERT_NOW(a_pad_zero, m_tvalid, out_pad == '0, "tdata padding not zero")

    `SDR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "beat lost")

endmodule

bind sandpile_drop_and_relax_unit sdr_checker u_sdr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/testbench.sv -----
// Testbench for the sandpile drop-and-relax unit: directed and random drops, grid predictor, result check.
module testbench;

    localparam int GRID_SIDE = 32;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int RAND_DROPS = 1900;

    typedef struct packed {
        logic [sdr_pkg::DROP_W-1:0] col;
        logic [sdr_pkg::DROP_W-1:0] row;
    } drop_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sdr_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sdr_pkg::M_TDATA_W-1:0] m_tdata;

    // grain counts of the predicted grid, cleared like the block at reset
    logic [15:0] pile [CELLS];

    drop_t            pending_drops[$];
    sdr_pkg::result_t expected_avalanches[$];
    int               drops_taken = 0;
    int               mismatches  = 0;

    sandpile_drop_and_relax_unit #(
        .GRID_SIDE(GRID_SIDE)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Add one grain and relax with a worklist; the count is order independent.
    function automatic sdr_pkg::result_t drop_grain(logic [sdr_pkg::DROP_W-1:0] row,
                                                    logic [sdr_pkg::DROP_W-1:0] col);
        int unsigned      work[$];
        longint unsigned  topplings;
        int unsigned      idx;
        int unsigned      k;
        int               r;
        int               c;
        int               nr;
        int               nc;
        int               nbr;
        sdr_pkg::result_t res;
        topplings = 0;
        if (int'(row) < GRID_SIDE && int'(col) < GRID_SIDE)
        begin
            idx = int'(row) * GRID_SIDE + int'(col);
            pile[idx] = pile[idx] + 16'd1;
            work.push_back(idx);
        end
        while (work.size() > 0)
        begin
            idx = work.pop_front();
            if (pile[idx] < sdr_pkg::TOPPLE_AT)
                continue;
            k = pile[idx] / sdr_pkg::TOPPLE_AT;
            pile[idx] = pile[idx] - 16'(k * sdr_pkg::TOPPLE_AT);
            topplings += k;
            r = idx / GRID_SIDE;
            c = idx % GRID_SIDE;
            for (nbr = 0; nbr < 4; nbr++)
            begin
                nr = r + ((nbr == 0) ? -1 : (nbr == 1) ? 1 : 0);
                nc = c + ((nbr == 2) ? -1 : (nbr == 3) ? 1 : 0);
                if (nr < 0 || nr >= GRID_SIDE || nc < 0 || nc >= GRID_SIDE)
                    continue;  // grain falls off the edge
                pile[nr * GRID_SIDE + nc] = pile[nr * GRID_SIDE + nc] + 16'(k);
                if (pile[nr * GRID_SIDE + nc] >= sdr_pkg::TOPPLE_AT)
                    work.push_back(nr * GRID_SIDE + nc);
            end
        end
        res.count = (topplings > sdr_pkg::COUNT_MAX) ? sdr_pkg::COUNT_MAX
                                                     : sdr_pkg::COUNT_W'(topplings);
        res.sat   = (res.count == sdr_pkg::COUNT_MAX);
        return res;
    endfunction

    // both sides run without gaps for a stretch in the middle of the random part
    function automatic bit take_break();
        if (drops_taken >= 700 && drops_taken < 1000)
            return 1'b0;
        return $urandom_range(99) < 34;
    endfunction

    task automatic queue_drop(int row, int col, int times);
        drop_t d;
        d.row = sdr_pkg::DROP_W'(row);
        d.col = sdr_pkg::DROP_W'(col);
        repeat (times) pending_drops.push_back(d);
    endtask

    task automatic flag_mismatch(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_drops
        drop_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_avalanches.push_back(drop_grain(s_tdata[4:0], s_tdata[9:5]));
                drops_taken <= drops_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_drops.size() > 0 && !take_break())
                begin
                    nxt = pending_drops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, nxt.col, nxt.row};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : check_avalanches
        sdr_pkg::result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_avalanches.size() == 0)
                    flag_mismatch("unexpected beat, topple_count", -1, m_tdata[23:0]);
                else
                begin
                    want = expected_avalanches.pop_front();
                    if (m_tdata[23:0] !== want.count)
                        flag_mismatch("topple_count", want.count, m_tdata[23:0]);
                    if (m_tdata[24] !== want.sat)
                        flag_mismatch("count_saturated", want.sat, m_tdata[24]);
                end
            end
            m_tready <= !take_break();
        end
    end

    initial
    begin : run_test
        int n;
        int pick;
        for (n = 0; n < CELLS; n++)
            pile[n] = 16'd0;

        // corners topple to two neighbors, edges to three, interior to four
        queue_drop(0, 0, 4);
        queue_drop(31, 31, 4);
        queue_drop(0, 17, 4);
        queue_drop(16, 31, 4);
        queue_drop(12, 9, 4);
        queue_drop(31, 0, 1);
        queue_drop(0, 31, 1);
        queue_drop(21, 14, 1);

        // center-heavy drops build up the pile quickly so big avalanches show up
        for (n = 0; n < RAND_DROPS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_drop($urandom_range(31), $urandom_range(31), 1);
            else if (pick < 80)
                queue_drop($urandom_range(19, 12), $urandom_range(19, 12), 1);
            else
                queue_drop(($urandom_range(1)) ? 31 : $urandom_range(1),
                           $urandom_range(31), 1);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_drops.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_avalanches.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // generous timeout for the whole run
    initial
    begin
        #600000000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sdr_pkg.sv
rtl/sdr_ram.sv
rtl/sdr_relax_ctrl.sv
rtl/sandpile_drop_and_relax_unit.sv
rtl/sdr_checker.sv
test/testbench.sv
